@@ hdl/s256rr_pkg.sv @@
// Shared types, constants and the round-constant table for the reduced-round SHA-256 core.
package s256rr_pkg;

    localparam int WORD_W     = 32;
    localparam int PAIR_W     = 64;
    localparam int CNT_W      = 7;
    localparam int KIDX_W     = 6;
    localparam int MAX_ROUNDS_DEF = 64;
    localparam int NUM_WORDS  = 8;
    localparam int WIN_LEN    = 16;

    typedef logic [WORD_W-1:0]               t_word;
    typedef logic [NUM_WORDS-1:0][WORD_W-1:0] t_work;
    typedef logic [WIN_LEN-1:0][WORD_W-1:0]   t_sched;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINAL,
        ST_OUT
    } t_state;

    localparam t_work INIT_HASH = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    // Round constant for round idx
    function automatic t_word round_const(input logic [KIDX_W-1:0] idx);
        t_word k;
        case (idx)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h00000000;
        endcase
        return k;
    endfunction

endpackage

@@ hdl/s256rr_blk_if.sv @@
// Message block channel: sixteen words packed two per field.
interface s256rr_blk_if;
    logic        valid;
    logic        ready;
    logic [63:0] words_0_1;
    logic [63:0] words_2_3;
    logic [63:0] words_4_5;
    logic [63:0] words_6_7;
    logic [63:0] words_8_9;
    logic [63:0] words_10_11;
    logic [63:0] words_12_13;
    logic [63:0] words_14_15;

    modport source (
        output valid, words_0_1, words_2_3, words_4_5, words_6_7,
               words_8_9, words_10_11, words_12_13, words_14_15,
        input  ready
    );
    modport sink (
        input  valid, words_0_1, words_2_3, words_4_5, words_6_7,
               words_8_9, words_10_11, words_12_13, words_14_15,
        output ready
    );
endinterface

@@ hdl/s256rr_dig_if.sv @@
// Digest channel: eight 32-bit result words.
interface s256rr_dig_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word_0;
    logic [31:0] digest_word_1;
    logic [31:0] digest_word_2;
    logic [31:0] digest_word_3;
    logic [31:0] digest_word_4;
    logic [31:0] digest_word_5;
    logic [31:0] digest_word_6;
    logic [31:0] digest_word_7;

    modport source (
        output valid, digest_word_0, digest_word_1, digest_word_2, digest_word_3,
               digest_word_4, digest_word_5, digest_word_6, digest_word_7,
        input  ready
    );
    modport sink (
        input  valid, digest_word_0, digest_word_1, digest_word_2, digest_word_3,
               digest_word_4, digest_word_5, digest_word_6, digest_word_7,
        output ready
    );
endinterface

@@ hdl/s256rr_cfg_if.sv @@
// Configuration write channel for the round count register.
interface s256rr_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] round_count;

    modport source (output valid, round_count, input ready);
    modport sink   (input valid, round_count, output ready);
endinterface

@@ hdl/s256rr_round.sv @@
// One SHA-256 round plus one message schedule expansion step, shared across all rounds.
module s256rr_round (
    input  s256rr_pkg::t_work  i_work,
    input  s256rr_pkg::t_sched i_sched,
    input  s256rr_pkg::t_word  i_k,
    output s256rr_pkg::t_work  o_work,
    output s256rr_pkg::t_word  o_wnext
);

    function automatic s256rr_pkg::t_word rotr(input s256rr_pkg::t_word x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    s256rr_pkg::t_word a, b, c, d, e, f, g, h;
    s256rr_pkg::t_word bs0, bs1, ch, maj, t1, t2, sg0, sg1;

    // Compress one round
    always_comb begin
        a = i_work[0]; b = i_work[1]; c = i_work[2]; d = i_work[3];
        e = i_work[4]; f = i_work[5]; g = i_work[6]; h = i_work[7];
        bs1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
        ch  = (e & f) ^ (~e & g);
        t1  = h + bs1 + ch + i_k + i_sched[0];
        bs0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
        maj = (a & b) ^ (a & c) ^ (b & c);
        t2  = bs0 + maj;
        o_work[7] = g;
        o_work[6] = f;
        o_work[5] = e;
        o_work[4] = d + t1;
        o_work[3] = c;
        o_work[2] = b;
        o_work[1] = a;
        o_work[0] = t1 + t2;
    end

    // Expand the word sixteen positions ahead of the window head
    always_comb begin
        sg0 = rotr(i_sched[1], 7) ^ rotr(i_sched[1], 18) ^ (i_sched[1] >> 3);
        sg1 = rotr(i_sched[14], 17) ^ rotr(i_sched[14], 19) ^ (i_sched[14] >> 10);
        o_wnext = i_sched[0] + sg0 + i_sched[9] + sg1;
    end

endmodule

@@ hdl/sha256_reduced_round_compress.sv @@
// Top level: reduced-round SHA-256 compression from the fixed initial hash value.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+----------------------------------------
//  i_cfg    | in  | valid/ready        | round_count (7 bits)
//  i_blk    | in  | valid/ready        | words_0_1 .. words_14_15 (8 x 64 bits)
//  o_dig    | out | valid/ready        | digest_word_0 .. digest_word_7 (32 bits)
//
// One round runs per cycle in a single shared round unit; an item passes through load,
// N rounds, final add and result, N being round_count capped at MAX_ROUNDS.
// i_blk is ready only while idle; the result holds in o_dig until it is taken.
// i_cfg is ready whenever out of reset. Reset is synchronous, active low; round_count
// resets to 64.
module sha256_reduced_round_compress #(
    parameter int MAX_ROUNDS = s256rr_pkg::MAX_ROUNDS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    s256rr_cfg_if.sink    i_cfg,
    s256rr_blk_if.sink    i_blk,
    s256rr_dig_if.source  o_dig
);

    localparam logic [s256rr_pkg::CNT_W-1:0] LIMIT = s256rr_pkg::CNT_W'(MAX_ROUNDS);

    s256rr_pkg::t_state r_state, n_state;
    logic [s256rr_pkg::CNT_W-1:0] r_round_count;
    logic [s256rr_pkg::CNT_W-1:0] r_limit, n_limit;
    logic [s256rr_pkg::CNT_W-1:0] r_rnd, n_rnd;
    s256rr_pkg::t_work  r_work, n_work;
    s256rr_pkg::t_sched r_sched, n_sched;
    s256rr_pkg::t_work  r_dig, n_dig;

    s256rr_pkg::t_work  rnd_work;
    s256rr_pkg::t_word  rnd_wnext;
    s256rr_pkg::t_sched blk_sched;
    logic               blk_acc;

    // Shared round unit
    s256rr_round u_round (
        .i_work  (r_work),
        .i_sched (r_sched),
        .i_k     (s256rr_pkg::round_const(r_rnd[s256rr_pkg::KIDX_W-1:0])),
        .o_work  (rnd_work),
        .o_wnext (rnd_wnext)
    );

    // Unpack the block, word 2k from the upper half of field k
    assign blk_sched = {
        i_blk.words_14_15[31:0], i_blk.words_14_15[63:32],
        i_blk.words_12_13[31:0], i_blk.words_12_13[63:32],
        i_blk.words_10_11[31:0], i_blk.words_10_11[63:32],
        i_blk.words_8_9[31:0],   i_blk.words_8_9[63:32],
        i_blk.words_6_7[31:0],   i_blk.words_6_7[63:32],
        i_blk.words_4_5[31:0],   i_blk.words_4_5[63:32],
        i_blk.words_2_3[31:0],   i_blk.words_2_3[63:32],
        i_blk.words_0_1[31:0],   i_blk.words_0_1[63:32]
    };

    // Hold both inputs off while in reset
    assign i_cfg.ready = i_rst_n;
    assign i_blk.ready = i_rst_n && (r_state == s256rr_pkg::ST_IDLE);
    assign blk_acc     = i_blk.valid && i_blk.ready;

    // Sequence load, rounds, final add and result
    always_comb begin
        n_state = r_state;
        n_limit = r_limit;
        n_rnd   = r_rnd;
        n_work  = r_work;
        n_sched = r_sched;
        n_dig   = r_dig;
        case (r_state)
            s256rr_pkg::ST_IDLE: begin
                if (blk_acc) begin
                    n_limit = (r_round_count > LIMIT) ? LIMIT : r_round_count;
                    n_rnd   = '0;
                    n_work  = s256rr_pkg::INIT_HASH;
                    n_sched = blk_sched;
                    n_state = (r_round_count == '0) ? s256rr_pkg::ST_FINAL
                                                    : s256rr_pkg::ST_ROUND;
                end
            end
            s256rr_pkg::ST_ROUND: begin
                n_work  = rnd_work;
                n_sched = {rnd_wnext, r_sched[s256rr_pkg::WIN_LEN-1:1]};
                n_rnd   = r_rnd + 1'b1;
                if (n_rnd == r_limit) begin
                    n_state = s256rr_pkg::ST_FINAL;
                end
            end
            s256rr_pkg::ST_FINAL: begin
                for (int i = 0; i < s256rr_pkg::NUM_WORDS; i++) begin
                    n_dig[i] = r_work[i] + s256rr_pkg::INIT_HASH[i];
                end
                n_state = s256rr_pkg::ST_OUT;
            end
            s256rr_pkg::ST_OUT: begin
                if (o_dig.ready) begin
                    n_state = s256rr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = s256rr_pkg::ST_IDLE;
            end
        endcase
    end

    // Hold control state and the configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= s256rr_pkg::ST_IDLE;
            r_round_count <= s256rr_pkg::CNT_W'(64);
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                r_round_count <= i_cfg.round_count;
            end
        end
    end

    // Advance the datapath registers
    always_ff @(posedge i_clk) begin
        r_limit <= n_limit;
        r_rnd   <= n_rnd;
        r_work  <= n_work;
        r_sched <= n_sched;
        r_dig   <= n_dig;
    end

    // Drive the result item
    assign o_dig.valid         = (r_state == s256rr_pkg::ST_OUT);
    assign o_dig.digest_word_0 = r_dig[0];
    assign o_dig.digest_word_1 = r_dig[1];
    assign o_dig.digest_word_2 = r_dig[2];
    assign o_dig.digest_word_3 = r_dig[3];
    assign o_dig.digest_word_4 = r_dig[4];
    assign o_dig.digest_word_5 = r_dig[5];
    assign o_dig.digest_word_6 = r_dig[6];
    assign o_dig.digest_word_7 = r_dig[7];

endmodule

@@ tb/sv/sha256_reduced_round_compress_tb.sv @@
// Self-checking testbench for the reduced-round SHA-256 compression block.
module sha256_reduced_round_compress_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          ROUND_LIMIT  = s256rr_pkg::MAX_ROUNDS_DEF;
    localparam int          RANDOM_ITEMS = 1100;
    localparam int          CYCLE_LIMIT  = 600000;
    localparam int          MAX_REPORTS  = 10;
    localparam int          NUM_DIRECTED = 21;

    // SHA-256 round constants
    localparam s256rr_pkg::t_word SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // With no rounds every digest word is twice the initial hash word
    localparam s256rr_pkg::t_work ZERO_ROUND_DIGEST = {
        32'hb7c19a32, 32'h3f07b356, 32'h360ad118, 32'ha21ca4fe,
        32'h4a9fea74, 32'h78dde6e4, 32'h76cf5d0a, 32'hd413ccce
    };

    // Message blocks, word 0 in the top 32 bits
    localparam logic [511:0] MSG_ZEROS = {16{32'h00000000}};
    localparam logic [511:0] MSG_ONES  = {16{32'hffffffff}};
    localparam logic [511:0] MSG_ALT_A = {16{32'haaaaaaaa}};
    localparam logic [511:0] MSG_ALT_5 = {16{32'h55555555}};
    localparam logic [511:0] MSG_ABC   = {32'h61626380, {14{32'h00000000}}, 32'h00000018};
    localparam logic [511:0] MSG_EMPTY = {32'h80000000, {15{32'h00000000}}};
    localparam logic [511:0] MSG_LAST  = {{15{32'h00000000}}, 32'hffffffff};
    localparam logic [511:0] MSG_COUNT = {
        32'h00010203, 32'h04050607, 32'h08090a0b, 32'h0c0d0e0f,
        32'h10111213, 32'h14151617, 32'h18191a1b, 32'h1c1d1e1f,
        32'h20212223, 32'h24252627, 32'h28292a2b, 32'h2c2d2e2f,
        32'h30313233, 32'h34353637, 32'h38393a3b, 32'h3c3d3e3f
    };

    typedef struct packed {
        logic [6:0]        rounds;
        logic [511:0]      msg;
        logic              has_known;
        s256rr_pkg::t_work known_dig;
    } t_stim_row;

    localparam t_stim_row DIRECTED_ROWS [NUM_DIRECTED] = '{
        // reset round count
        '{7'd64,  MSG_ZEROS, 1'b0, '0},
        '{7'd64,  MSG_ONES,  1'b0, '0},
        '{7'd64,  MSG_ALT_A, 1'b0, '0},
        '{7'd64,  MSG_ALT_5, 1'b0, '0},
        '{7'd64,  MSG_ABC,   1'b0, '0},
        '{7'd64,  MSG_EMPTY, 1'b0, '0},
        // zero rounds ignore the block
        '{7'd0,   MSG_ONES,  1'b1, ZERO_ROUND_DIGEST},
        '{7'd0,   MSG_ZEROS, 1'b1, ZERO_ROUND_DIGEST},
        '{7'd0,   MSG_ALT_A, 1'b1, ZERO_ROUND_DIGEST},
        // short counts use only the leading words
        '{7'd1,   MSG_ONES,  1'b0, '0},
        '{7'd1,   MSG_COUNT, 1'b0, '0},
        '{7'd15,  MSG_ONES,  1'b0, '0},
        '{7'd15,  MSG_LAST,  1'b0, '0},
        // first expanded schedule words
        '{7'd16,  MSG_ONES,  1'b0, '0},
        '{7'd17,  MSG_ONES,  1'b0, '0},
        '{7'd17,  MSG_LAST,  1'b0, '0},
        '{7'd63,  MSG_ALT_A, 1'b0, '0},
        // oversized counts saturate
        '{7'd65,  MSG_ONES,  1'b0, '0},
        '{7'd127, MSG_ZEROS, 1'b0, '0},
        '{7'd127, MSG_ONES,  1'b0, '0},
        '{7'd100, MSG_ABC,   1'b0, '0}
    };

    logic i_clk;
    logic i_rst_n;

    s256rr_cfg_if cfg_ch ();
    s256rr_blk_if blk_ch ();
    s256rr_dig_if dig_ch ();

    s256rr_pkg::t_work pending_digests [$];
    logic [6:0]        round_count_q;
    int                fault_count;
    bit                src_burst;

    sha256_reduced_round_compress #(
        .MAX_ROUNDS (ROUND_LIMIT)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_blk   (blk_ch),
        .o_dig   (dig_ch)
    );

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Rotate a word right by n bits, n in 1..31
    function automatic s256rr_pkg::t_word ror32(input s256rr_pkg::t_word x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Compress one block from the initial hash for the given round count
    function automatic s256rr_pkg::t_work compress_block(input logic [511:0] msg,
                                                         input logic [6:0] cnt);
        s256rr_pkg::t_word w [64];
        s256rr_pkg::t_work v;
        s256rr_pkg::t_word s0;
        s256rr_pkg::t_word s1;
        s256rr_pkg::t_word t1;
        s256rr_pkg::t_word t2;
        int unsigned       rounds;
        int                i;
        rounds = (cnt > ROUND_LIMIT) ? ROUND_LIMIT : cnt;
        if (rounds > 64) begin
            rounds = 64;
        end
        for (i = 0; i < 64; i++) begin
            w[i] = '0;
        end
        for (i = 0; i < 16; i++) begin
            w[i] = msg[511 - 32 * i -: 32];
        end
        // expand the schedule only as far as the rounds need
        for (i = 16; i < rounds; i++) begin
            s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        v = s256rr_pkg::INIT_HASH;
        for (i = 0; i < rounds; i++) begin
            s1 = ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25);
            t1 = v[7] + s1 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[i] + w[i];
            s0 = ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22);
            t2 = s0 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (i = 0; i < s256rr_pkg::NUM_WORDS; i++) begin
            v[i] = v[i] + s256rr_pkg::INIT_HASH[i];
        end
        return v;
    endfunction

    // Count a failure and print the first few
    task automatic report_fault(input string msg);
        fault_count++;
        if (fault_count <= MAX_REPORTS) begin
            $display("%s", msg);
        end
    endtask

    // Write the round count once every pending digest has been taken
    task automatic write_round_count(input logic [6:0] value);
        while (pending_digests.size() != 0) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        cfg_ch.round_count = value;
        cfg_ch.valid       = 1'b1;
        @(posedge i_clk);
        while (cfg_ch.ready !== 1'b1) begin
            @(posedge i_clk);
        end
        round_count_q = value;
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Offer one block after a random gap; queue its digest when accepted
    task automatic send_block(input logic [511:0] msg, input s256rr_pkg::t_work want);
        int unsigned gap;
        if ($urandom_range(15) == 0) begin
            src_burst = !src_burst;
        end
        gap = src_burst ? 0 : $urandom_range(18);
        if (gap != 0) begin
            blk_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        blk_ch.words_0_1   = msg[511:448];
        blk_ch.words_2_3   = msg[447:384];
        blk_ch.words_4_5   = msg[383:320];
        blk_ch.words_6_7   = msg[319:256];
        blk_ch.words_8_9   = msg[255:192];
        blk_ch.words_10_11 = msg[191:128];
        blk_ch.words_12_13 = msg[127:64];
        blk_ch.words_14_15 = msg[63:0];
        blk_ch.valid       = 1'b1;
        @(posedge i_clk);
        while (blk_ch.ready !== 1'b1) begin
            @(posedge i_clk);
        end
        pending_digests.push_back(want);
        @(negedge i_clk);
        // drop valid so the taken block is not offered again
        blk_ch.valid = 1'b0;
    endtask

    // Accept digests after random stalls and check each against the oldest expectation
    initial begin : digest_sink
        int unsigned       gap;
        bit                burst;
        s256rr_pkg::t_work got;
        s256rr_pkg::t_work want;
        int                k;
        dig_ch.ready = 1'b0;
        burst        = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if ($urandom_range(15) == 0) begin
                burst = !burst;
            end
            gap = burst ? 0 : $urandom_range(18);
            if (gap != 0) begin
                dig_ch.ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            dig_ch.ready = 1'b1;
            @(posedge i_clk);
            while (dig_ch.valid !== 1'b1) begin
                @(posedge i_clk);
            end
            got = {dig_ch.digest_word_7, dig_ch.digest_word_6, dig_ch.digest_word_5,
                   dig_ch.digest_word_4, dig_ch.digest_word_3, dig_ch.digest_word_2,
                   dig_ch.digest_word_1, dig_ch.digest_word_0};
            if (pending_digests.size() == 0) begin
                report_fault($sformatf("unexpected digest %h", got));
            end else begin
                want = pending_digests.pop_front();
                for (k = 0; k < s256rr_pkg::NUM_WORDS; k++) begin
                    if (got[k] !== want[k]) begin
                        report_fault($sformatf("digest_word_%0d: expected %08h, got %08h",
                                               k, want[k], got[k]));
                    end
                end
            end
            @(negedge i_clk);
        end
    end

    // Abort a run that stops making progress
    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("** sha256_reduced_round_compress: FAILED **");
        $finish;
    end

    // Reset, directed table, random phases, drain
    initial begin : stimulus
        t_stim_row    row;
        logic [511:0] msg;
        logic [6:0]   count;
        int           sent;
        int           phase_len;
        int           w;
        fault_count        = 0;
        src_burst          = 1'b0;
        round_count_q      = 7'd64;
        i_rst_n            = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.round_count = '0;
        blk_ch.valid       = 1'b0;
        blk_ch.words_0_1   = '0;
        blk_ch.words_2_3   = '0;
        blk_ch.words_4_5   = '0;
        blk_ch.words_6_7   = '0;
        blk_ch.words_8_9   = '0;
        blk_ch.words_10_11 = '0;
        blk_ch.words_12_13 = '0;
        blk_ch.words_14_15 = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Walk the directed table; the first rows run on the reset round count
        for (int r = 0; r < NUM_DIRECTED; r++) begin
            row = DIRECTED_ROWS[r];
            if (row.rounds != round_count_q) begin
                write_round_count(row.rounds);
            end
            send_block(row.msg, row.has_known ? row.known_dig
                                              : compress_block(row.msg, round_count_q));
        end

        // Random phases, each with its own round count
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(9))
                0:       count = 7'd0;
                1:       count = 7'($urandom_range(15, 1));
                2:       count = 7'($urandom_range(17, 16));
                3, 4:    count = 7'($urandom_range(63, 18));
                5, 6:    count = 7'd64;
                7:       count = 7'($urandom_range(127, 65));
                8:       count = 7'd63;
                default: count = 7'($urandom_range(127));
            endcase
            write_round_count(count);
            phase_len = $urandom_range(60, 10);
            repeat (phase_len) begin
                // mostly random words, with corner patterns mixed in
                for (w = 0; w < 16; w++) begin
                    case ($urandom_range(9))
                        0:       msg[511 - 32 * w -: 32] = 32'h00000000;
                        1:       msg[511 - 32 * w -: 32] = 32'hffffffff;
                        2:       msg[511 - 32 * w -: 32] = 32'h1 << $urandom_range(31);
                        3:       msg[511 - 32 * w -: 32] = ~(32'h1 << $urandom_range(31));
                        default: msg[511 - 32 * w -: 32] = $urandom;
                    endcase
                end
                send_block(msg, compress_block(msg, round_count_q));
                sent++;
            end
        end
        blk_ch.valid = 1'b0;

        // Drain outstanding digests, then watch for strays
        while (pending_digests.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (ROUND_LIMIT + 8) @(posedge i_clk);
        if (pending_digests.size() != 0) begin
            report_fault($sformatf("%0d digests never arrived", pending_digests.size()));
        end
        if (fault_count == 0) begin
            $display("** sha256_reduced_round_compress: PASSED **");
        end else begin
            $display("** sha256_reduced_round_compress: FAILED **");
        end
        $finish;
    end

endmodule
